// ----- hdl/stb_pkg.sv -----
// Shared types, constants and the texel swizzle function for the blitter.
// No dependencies; the controller, the datapath and the top level use it.
package stb_pkg;

  localparam int COORD_W    = 12;            // pos_x, pos_y, size and counters
  localparam int TX_W       = COORD_W + 1;   // origin plus counter
  localparam int SCALE_W    = 4;
  localparam int FB_W       = 13;            // fb_width, fb_height
  localparam int BASE_W     = TX_W + SCALE_W; // scaled pixel coordinate
  localparam int PROD_W     = BASE_W + FB_W;
  localparam int IDX_W      = 24;
  localparam int COLOR_W    = 32;
  localparam int RGB_W      = 24;
  localparam int FMT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [COLOR_W-1:0] COLOR_KEY = 32'h00FF_11FF;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_TEXEL  = 2'd1,
    CMD_RAW    = 2'd2,
    CMD_SCALED = 2'd3
  } cmd_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB  = 3'd0,
    FMT_BGR  = 3'd1,
    FMT_ARGB = 3'd2,
    FMT_ABGR = 3'd3,
    FMT_RGBA = 3'd4,
    FMT_BGRA = 3'd5
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE     = 3'd0,
    CFG_TILE_COLS = 3'd1,
    CFG_TILE_ROWS = 3'd2,
    CFG_FB_WIDTH  = 3'd3,
    CFG_FB_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADDR = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic load_addr;  // form the start index of the block
    logic emit;       // load the next write into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go;        // accepted item produces at least one write
    logic out_free;  // output register can take a write this cycle
    logic blk_end;   // current write is the final one of the block
  } dp_stat_t;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic             alpha_nz;
  } texel_t;

  // Reorder texel bytes to 0xRRGGBB; three-byte formats count as opaque.
  function automatic texel_t swizzle(input logic [FMT_W-1:0] fmt,
                                     input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3);
    texel_t t;
    t.alpha_nz = 1'b1;
    t.rgb      = {b0, b1, b2};
    case (fmt)
      FMT_RGB: begin
        t.rgb = {b0, b1, b2};
      end
      FMT_BGR: begin
        t.rgb = {b2, b1, b0};
      end
      FMT_ARGB: begin
        t.rgb      = {b1, b2, b3};
        t.alpha_nz = (b0 != 8'd0);
      end
      FMT_ABGR: begin
        t.rgb      = {b3, b2, b1};
        t.alpha_nz = (b0 != 8'd0);
      end
      FMT_RGBA: begin
        t.rgb      = {b0, b1, b2};
        t.alpha_nz = (b3 != 8'd0);
      end
      default: begin
        t.rgb      = {b2, b1, b0};
        t.alpha_nz = (b3 != 8'd0);
      end
    endcase
    return t;
  endfunction

endpackage

// ----- hdl/stb_ctrl.sv -----
// Sequencing state machine of the blitter: accept, address setup, write burst.
// Depends on stb_pkg for the state enum and the command/status structs.
module stb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stb_pkg::dp_stat_t    stat,
  output stb_pkg::ctrl_cmd_t   cmd
);

  stb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = 1'b0;
    cmd.load_addr = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state_r)
      stb_pkg::ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && stat.go) begin
          state_nxt = stb_pkg::ST_ADDR;
        end
      end
      stb_pkg::ST_ADDR: begin
        cmd.load_addr = 1'b1;
        state_nxt     = stb_pkg::ST_EMIT;
      end
      stb_pkg::ST_EMIT: begin
        // advance only when the output register has room
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.blk_end) begin
          state_nxt = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stb_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != stb_pkg::ST_IDLE);

endmodule

// ----- hdl/stb_dpath.sv -----
// Datapath of the blitter: configuration and blit state, texel decode,
// clipping, block address generation and the output register. Uses stb_pkg.
module stb_dpath #(
  parameter int MAX_SCALE = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stb_pkg::ctrl_cmd_t                 cmd,
  output stb_pkg::dp_stat_t                  stat,
  input  logic                               cfg_we,
  input  logic [stb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [1:0]                         in_command,
  input  logic [stb_pkg::COORD_W-1:0]        in_pos_x,
  input  logic [stb_pkg::COORD_W-1:0]        in_pos_y,
  input  logic [stb_pkg::COORD_W-1:0]        in_size_w,
  input  logic [stb_pkg::COORD_W-1:0]        in_size_h,
  input  logic [stb_pkg::FMT_W-1:0]          in_pixel_format,
  input  logic [7:0]                         in_byte0,
  input  logic [7:0]                         in_byte1,
  input  logic [7:0]                         in_byte2,
  input  logic [7:0]                         in_byte3,
  input  logic [stb_pkg::COLOR_W-1:0]        in_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stb_pkg::IDX_W-1:0]          out_fb_index,
  output logic [stb_pkg::COLOR_W-1:0]        out_fb_color,
  output logic                               out_last_write
);

  localparam int CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam logic [stb_pkg::SCALE_W-1:0] SMAX = stb_pkg::SCALE_W'(MAX_SCALE);

  // configuration
  logic [stb_pkg::SCALE_W-1:0] scale_r;
  logic [stb_pkg::COORD_W-1:0] tile_cols_r, tile_rows_r;
  logic [stb_pkg::FB_W-1:0]    fb_width_r, fb_height_r;

  // blit state
  logic [stb_pkg::COORD_W-1:0] origin_x_r, origin_y_r, blit_width_r, blit_height_r;
  logic [stb_pkg::FMT_W-1:0]   byte_order_r;
  logic [stb_pkg::COORD_W-1:0] column_count_r, row_count_r;
  logic [stb_pkg::COORD_W-1:0] column_count_nxt, row_count_nxt;
  logic                        blit_active_r;

  // block in flight
  logic [stb_pkg::BASE_W-1:0]  base_x_r, base_y_r;
  logic [stb_pkg::COLOR_W-1:0] color_r;
  logic [CNT_W-1:0]            sm1_r, i_r, j_r;
  logic [stb_pkg::IDX_W-1:0]   row_idx_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [stb_pkg::IDX_W-1:0]   out_fb_index_r;
  logic [stb_pkg::COLOR_W-1:0] out_fb_color_r;
  logic                        out_last_r;

  stb_pkg::cmd_t               in_cmd;
  stb_pkg::texel_t             sw;
  logic [stb_pkg::SCALE_W-1:0] s_eff, s_sel;
  logic                        texel_live, blk_ok, raw_ok, go;
  logic [stb_pkg::TX_W-1:0]    tx, ty, bx, by;
  logic [stb_pkg::COLOR_W-1:0] bcol;
  logic [stb_pkg::COORD_W-1:0] col_inc;
  logic [stb_pkg::BASE_W-1:0]  base_x_nxt, base_y_nxt;
  logic [stb_pkg::PROD_W-1:0]  prod;
  logic                        row_end, blk_end;

  assign in_cmd     = stb_pkg::cmd_t'(in_command);
  assign sw         = stb_pkg::swizzle(byte_order_r, in_byte0, in_byte1, in_byte2, in_byte3);
  assign s_eff      = (scale_r > SMAX) ? SMAX : scale_r;
  assign s_sel      = (in_cmd == stb_pkg::CMD_RAW) ? stb_pkg::SCALE_W'(1) : s_eff;
  assign texel_live = blit_active_r && (blit_width_r != '0) && (row_count_r < blit_height_r);

  assign tx = {1'b0, origin_x_r} + {1'b0, column_count_r};
  assign ty = {1'b0, origin_y_r} + {1'b0, row_count_r};

  always_comb begin
    if (in_cmd == stb_pkg::CMD_TEXEL) begin
      bx   = tx;
      by   = ty;
      bcol = {{(stb_pkg::COLOR_W - stb_pkg::RGB_W){1'b0}}, sw.rgb};
    end else begin
      bx   = {1'b0, in_pos_x};
      by   = {1'b0, in_pos_y};
      bcol = in_color;
    end
  end

  assign blk_ok = (bx < {1'b0, tile_cols_r}) && (by < {1'b0, tile_rows_r}) &&
                  (bcol != stb_pkg::COLOR_KEY) && (s_eff != '0);
  assign raw_ok = ({1'b0, in_pos_x} < fb_width_r) && ({1'b0, in_pos_y} < fb_height_r) &&
                  (in_color != stb_pkg::COLOR_KEY);

  always_comb begin
    unique case (in_cmd)
      stb_pkg::CMD_BEGIN:  go = 1'b0;
      stb_pkg::CMD_TEXEL:  go = texel_live && sw.alpha_nz && blk_ok;
      stb_pkg::CMD_RAW:    go = raw_ok;
      stb_pkg::CMD_SCALED: go = blk_ok;
      default:             go = 1'b0;
    endcase
  end

  // scaled top-left corner of the block
  assign base_x_nxt = {{stb_pkg::SCALE_W{1'b0}}, bx} * {{stb_pkg::TX_W{1'b0}}, s_sel};
  assign base_y_nxt = {{stb_pkg::SCALE_W{1'b0}}, by} * {{stb_pkg::TX_W{1'b0}}, s_sel};
  assign prod       = {{stb_pkg::FB_W{1'b0}}, base_y_r} *
                      {{stb_pkg::BASE_W{1'b0}}, fb_width_r};

  // texel counters advance even when the texel is skipped or clipped
  assign col_inc = column_count_r + stb_pkg::COORD_W'(1);
  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (cmd.accept) begin
      if (in_cmd == stb_pkg::CMD_BEGIN) begin
        column_count_nxt = '0;
        row_count_nxt    = '0;
      end else if (in_cmd == stb_pkg::CMD_TEXEL && texel_live) begin
        if (col_inc >= blit_width_r) begin
          column_count_nxt = '0;
          row_count_nxt    = row_count_r + stb_pkg::COORD_W'(1);
        end else begin
          column_count_nxt = col_inc;
        end
      end
    end
  end

  assign row_end = (i_r == sm1_r);
  assign blk_end = row_end && (j_r == sm1_r);

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and programmed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r        <= stb_pkg::SCALE_W'(1);
      tile_cols_r    <= '0;
      tile_rows_r    <= '0;
      fb_width_r     <= stb_pkg::FB_W'(1);
      fb_height_r    <= stb_pkg::FB_W'(1);
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      blit_width_r   <= '0;
      blit_height_r  <= '0;
      byte_order_r   <= '0;
      column_count_r <= '0;
      row_count_r    <= '0;
      blit_active_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          stb_pkg::CFG_SCALE:     scale_r     <= cfg_wdata[stb_pkg::SCALE_W-1:0];
          stb_pkg::CFG_TILE_COLS: tile_cols_r <= cfg_wdata[stb_pkg::COORD_W-1:0];
          stb_pkg::CFG_TILE_ROWS: tile_rows_r <= cfg_wdata[stb_pkg::COORD_W-1:0];
          stb_pkg::CFG_FB_WIDTH:  fb_width_r  <= cfg_wdata[stb_pkg::FB_W-1:0];
          stb_pkg::CFG_FB_HEIGHT: fb_height_r <= cfg_wdata[stb_pkg::FB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && in_cmd == stb_pkg::CMD_BEGIN) begin
        origin_x_r    <= in_pos_x;
        origin_y_r    <= in_pos_y;
        blit_width_r  <= in_size_w;
        blit_height_r <= in_size_h;
        byte_order_r  <= in_pixel_format;
        blit_active_r <= (in_pos_x < tile_cols_r) && (in_pos_y < tile_rows_r) &&
                         (in_pixel_format <= stb_pkg::FMT_BGRA);
      end
    end
  end

  // block payload and write generation
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
      color_r  <= bcol;
      sm1_r    <= CNT_W'(s_sel - stb_pkg::SCALE_W'(1));
    end
    if (cmd.load_addr) begin
      row_idx_r <= prod[stb_pkg::IDX_W-1:0] +
                   {{(stb_pkg::IDX_W - stb_pkg::BASE_W){1'b0}}, base_x_r};
      i_r       <= '0;
      j_r       <= '0;
    end else if (cmd.emit) begin
      out_fb_index_r <= row_idx_r + {{(stb_pkg::IDX_W - CNT_W){1'b0}}, i_r};
      out_fb_color_r <= color_r;
      out_last_r     <= blk_end;
      if (row_end) begin
        i_r       <= '0;
        j_r       <= j_r + CNT_W'(1);
        row_idx_r <= row_idx_r + {{(stb_pkg::IDX_W - stb_pkg::FB_W){1'b0}}, fb_width_r};
      end else begin
        i_r <= i_r + CNT_W'(1);
      end
    end
  end

  assign stat.go       = go;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.blk_end  = blk_end;

  assign out_valid      = out_valid_r;
  assign out_fb_index   = out_fb_index_r;
  assign out_fb_color   = out_fb_color_r;
  assign out_last_write = out_last_r;

endmodule

// ----- hdl/scaled_texture_blitter.sv -----
// Top level of the scaled texture blitter: controller plus datapath.
// Depends on stb_pkg, stb_ctrl and stb_dpath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in_     | in        | in_valid/in_stall  | command, pos, size, format, bytes, color
//  out_    | out       | out_valid/out_stall| fb_index, fb_color, last_write
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata (write only)
//
// An item that writes nothing (begin, skipped, clipped or keyed texel) leaves the block idle.
// An item with writes gives s*s writes, s = min(scale, MAX_SCALE) or 1 for a raw
// pixel: the accept, an address step for the y * fb_width multiply, then one write per
// cycle out of the single output register while the output does not stall.
// Reset is synchronous and active low; all config and blit state return to defaults.
// A stall on the output holds the write burst; in_stall stays high until the last
// write of the item has been loaded into the output register.
module scaled_texture_blitter #(
  parameter int MAX_SCALE = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [stb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_command,
  input  logic [stb_pkg::COORD_W-1:0]        in_pos_x,
  input  logic [stb_pkg::COORD_W-1:0]        in_pos_y,
  input  logic [stb_pkg::COORD_W-1:0]        in_size_w,
  input  logic [stb_pkg::COORD_W-1:0]        in_size_h,
  input  logic [stb_pkg::FMT_W-1:0]          in_pixel_format,
  input  logic [7:0]                         in_byte0,
  input  logic [7:0]                         in_byte1,
  input  logic [7:0]                         in_byte2,
  input  logic [7:0]                         in_byte3,
  input  logic [stb_pkg::COLOR_W-1:0]        in_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stb_pkg::IDX_W-1:0]          out_fb_index,
  output logic [stb_pkg::COLOR_W-1:0]        out_fb_color,
  output logic                               out_last_write
);

  stb_pkg::ctrl_cmd_t cmd;
  stb_pkg::dp_stat_t  stat;

  // sequencing: accept, address setup, write burst
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state, decode, clipping and address generation
  stb_dpath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_size_w       (in_size_w),
    .in_size_h       (in_size_h),
    .in_pixel_format (in_pixel_format),
    .in_byte0        (in_byte0),
    .in_byte1        (in_byte1),
    .in_byte2        (in_byte2),
    .in_byte3        (in_byte3),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fb_index    (out_fb_index),
    .out_fb_color    (out_fb_color),
    .out_last_write  (out_last_write)
  );

  // a write that is not the last of its item leaves the block busy
  a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_write) |-> in_stall)
    else $error("input accepted while a write burst is unfinished");

  // new writes appear only out of a burst
  a_write_from_burst: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("write produced outside a burst");

  // a begin command produces no write
  a_begin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == stb_pkg::CMD_BEGIN && !out_valid)
      |=> !out_valid)
    else $error("begin command produced a write");

endmodule

// ----- test/scaled_texture_blitter_test.sv -----
// Self-checking testbench for scaled_texture_blitter: directed and random command streams.
// The testbench predicts the framebuffer writes itself and compares each one as it arrives.
// Depends on stb_pkg and the scaled_texture_blitter RTL only.
module scaled_texture_blitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLIT_MAX_SCALE = 8;
  localparam int SETTLE_CYCLES  = 20;    // idle clocks after the last owed write; leave margin
  localparam int LONG_HOLD      = 300;   // receiver hold-off in the backpressure test
  localparam int PHASE_ITEMS    = 16;    // minimum applied items per random phase, four phases
  localparam longint RUN_LIMIT_NS = 2_000_000;

  // Format code that the block must reject at begin time.
  localparam logic [stb_pkg::FMT_W-1:0] FMT_INVALID = 3'd7;

  typedef struct {
    stb_pkg::cmd_t                command;
    logic [stb_pkg::COORD_W-1:0]  pos_x;
    logic [stb_pkg::COORD_W-1:0]  pos_y;
    logic [stb_pkg::COORD_W-1:0]  size_w;
    logic [stb_pkg::COORD_W-1:0]  size_h;
    logic [stb_pkg::FMT_W-1:0]    fmt;
    logic [7:0]                   byte0;
    logic [7:0]                   byte1;
    logic [7:0]                   byte2;
    logic [7:0]                   byte3;
    logic [stb_pkg::COLOR_W-1:0]  color;
  } blit_req_t;

  typedef struct {
    logic [stb_pkg::IDX_W-1:0]   index;
    logic [stb_pkg::COLOR_W-1:0] color;
    logic                        last;
  } fb_write_t;

  // DUT connections
  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [stb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [stb_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [1:0]                     in_command;
  logic [stb_pkg::COORD_W-1:0]    in_pos_x;
  logic [stb_pkg::COORD_W-1:0]    in_pos_y;
  logic [stb_pkg::COORD_W-1:0]    in_size_w;
  logic [stb_pkg::COORD_W-1:0]    in_size_h;
  logic [stb_pkg::FMT_W-1:0]      in_pixel_format;
  logic [7:0]                     in_byte0;
  logic [7:0]                     in_byte1;
  logic [7:0]                     in_byte2;
  logic [7:0]                     in_byte3;
  logic [stb_pkg::COLOR_W-1:0]    in_color;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [stb_pkg::IDX_W-1:0]      out_fb_index;
  logic [stb_pkg::COLOR_W-1:0]    out_fb_color;
  logic                           out_last_write;

  // Testbench copy of the configuration registers
  logic [stb_pkg::SCALE_W-1:0]    scale_reg;
  logic [stb_pkg::COORD_W-1:0]    tile_cols_reg;
  logic [stb_pkg::COORD_W-1:0]    tile_rows_reg;
  logic [stb_pkg::FB_W-1:0]       fb_width_reg;
  logic [stb_pkg::FB_W-1:0]       fb_height_reg;

  // Testbench copy of the blit state
  logic [stb_pkg::COORD_W-1:0]    org_x;
  logic [stb_pkg::COORD_W-1:0]    org_y;
  logic [stb_pkg::COORD_W-1:0]    blit_w;
  logic [stb_pkg::COORD_W-1:0]    blit_h;
  logic [stb_pkg::FMT_W-1:0]      blit_fmt;
  logic [stb_pkg::COORD_W-1:0]    col_cnt;
  logic [stb_pkg::COORD_W-1:0]    row_cnt;
  logic                           blit_on;

  fb_write_t pending_writes[$];   // writes still owed by the block, oldest first
  int        mismatch_count = 0;
  int        items_applied  = 0;  // items that the block acts upon
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_requests  = 0;  // bumped by a test to ask for a long hold-off
  int        hold_served    = 0;
  int        hold_left      = 0;

  scaled_texture_blitter #(
    .MAX_SCALE(BLIT_MAX_SCALE)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_size_w      (in_size_w),
    .in_size_h      (in_size_h),
    .in_pixel_format(in_pixel_format),
    .in_byte0       (in_byte0),
    .in_byte1       (in_byte1),
    .in_byte2       (in_byte2),
    .in_byte3       (in_byte3),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fb_index   (out_fb_index),
    .out_fb_color   (out_fb_color),
    .out_last_write (out_last_write)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Write prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_predictor();
    scale_reg     = 4'd1;
    tile_cols_reg = '0;
    tile_rows_reg = '0;
    fb_width_reg  = 13'd1;
    fb_height_reg = 13'd1;
    org_x    = '0;
    org_y    = '0;
    blit_w   = '0;
    blit_h   = '0;
    blit_fmt = '0;
    col_cnt  = '0;
    row_cnt  = '0;
    blit_on  = 1'b0;
  endfunction

  // One framebuffer write; the index wraps to the width of the port.
  function automatic void queue_write(input longint unsigned x, input longint unsigned y,
                                      input logic [stb_pkg::COLOR_W-1:0] color);
    fb_write_t w;
    longint unsigned idx;
    idx     = x + y * longint'(fb_width_reg);
    w.index = idx[stb_pkg::IDX_W-1:0];
    w.color = color;
    w.last  = 1'b0;
    pending_writes.push_back(w);
  endfunction

  // Replicate one tile into a scale-by-scale block unless clipped or keyed.
  function automatic void queue_block(input logic [stb_pkg::TX_W-1:0] tx,
                                      input logic [stb_pkg::TX_W-1:0] ty,
                                      input logic [stb_pkg::COLOR_W-1:0] color);
    int unsigned s;
    s = (scale_reg > BLIT_MAX_SCALE) ? BLIT_MAX_SCALE : scale_reg;
    if (tx >= tile_cols_reg || ty >= tile_rows_reg || color == stb_pkg::COLOR_KEY)
      return;
    for (int unsigned j = 0; j < s; j++)
      for (int unsigned i = 0; i < s; i++)
        queue_write(longint'(tx) * s + i, longint'(ty) * s + j, color);
  endfunction

  // Work out the writes caused by one accepted item and advance the blit state.
  // Returns 0 for a texel that the block merely ignores.
  function automatic bit predict_fb_writes(input blit_req_t r);
    int                       first;
    bit                       effective;
    logic [7:0]               red, green, blue, alpha;
    logic [stb_pkg::TX_W-1:0] tx, ty;
    first     = pending_writes.size();
    effective = 1'b1;
    case (r.command)
      stb_pkg::CMD_BEGIN: begin
        org_x    = r.pos_x;
        org_y    = r.pos_y;
        blit_w   = r.size_w;
        blit_h   = r.size_h;
        blit_fmt = r.fmt;
        col_cnt  = '0;
        row_cnt  = '0;
        blit_on  = r.pos_x < tile_cols_reg && r.pos_y < tile_rows_reg &&
                   r.fmt <= stb_pkg::FMT_BGRA;
      end
      stb_pkg::CMD_TEXEL: begin
        if (!blit_on || blit_w == 0 || row_cnt >= blit_h) begin
          effective = 1'b0;
        end else begin
          alpha = 8'd1;
          case (blit_fmt)
            stb_pkg::FMT_RGB: begin
              red = r.byte0; green = r.byte1; blue = r.byte2;
            end
            stb_pkg::FMT_BGR: begin
              red = r.byte2; green = r.byte1; blue = r.byte0;
            end
            stb_pkg::FMT_ARGB: begin
              alpha = r.byte0; red = r.byte1; green = r.byte2; blue = r.byte3;
            end
            stb_pkg::FMT_ABGR: begin
              alpha = r.byte0; red = r.byte3; green = r.byte2; blue = r.byte1;
            end
            stb_pkg::FMT_RGBA: begin
              red = r.byte0; green = r.byte1; blue = r.byte2; alpha = r.byte3;
            end
            default: begin
              red = r.byte2; green = r.byte1; blue = r.byte0; alpha = r.byte3;
            end
          endcase
          tx = org_x + col_cnt;
          ty = org_y + row_cnt;
          if (alpha != 8'd0)
            queue_block(tx, ty, {8'h00, red, green, blue});
          // skipped and clipped texels still advance the raster position
          col_cnt = col_cnt + 1'b1;
          if (col_cnt >= blit_w) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
          end
        end
      end
      stb_pkg::CMD_RAW: begin
        if (r.pos_x < fb_width_reg && r.pos_y < fb_height_reg &&
            r.color != stb_pkg::COLOR_KEY)
          queue_write(r.pos_x, r.pos_y, r.color);
      end
      default: begin
        queue_block(r.pos_x, r.pos_y, r.color);
      end
    endcase
    if (pending_writes.size() > first)
      pending_writes[pending_writes.size() - 1].last = 1'b1;
    return effective;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders: every field starts random, the command fixes what matters
  // ---------------------------------------------------------------------------

  function automatic blit_req_t random_req();
    blit_req_t r;
    r.command = stb_pkg::cmd_t'($urandom_range(0, 3));
    r.pos_x   = stb_pkg::COORD_W'($urandom_range(0, 4095));
    r.pos_y   = stb_pkg::COORD_W'($urandom_range(0, 4095));
    r.size_w  = stb_pkg::COORD_W'($urandom_range(0, 4095));
    r.size_h  = stb_pkg::COORD_W'($urandom_range(0, 4095));
    r.fmt     = stb_pkg::FMT_W'($urandom_range(0, 7));
    r.byte0   = 8'($urandom_range(0, 255));
    r.byte1   = 8'($urandom_range(0, 255));
    r.byte2   = 8'($urandom_range(0, 255));
    r.byte3   = 8'($urandom_range(0, 255));
    r.color   = $urandom;
    return r;
  endfunction

  function automatic blit_req_t begin_req(input int x, input int y, input int w, input int h,
                                          input logic [stb_pkg::FMT_W-1:0] fmt);
    blit_req_t r;
    r         = random_req();
    r.command = stb_pkg::CMD_BEGIN;
    r.pos_x   = stb_pkg::COORD_W'(x);
    r.pos_y   = stb_pkg::COORD_W'(y);
    r.size_w  = stb_pkg::COORD_W'(w);
    r.size_h  = stb_pkg::COORD_W'(h);
    r.fmt     = fmt;
    return r;
  endfunction

  function automatic blit_req_t texel_req(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3);
    blit_req_t r;
    r         = random_req();
    r.command = stb_pkg::CMD_TEXEL;
    r.byte0   = b0;
    r.byte1   = b1;
    r.byte2   = b2;
    r.byte3   = b3;
    return r;
  endfunction

  function automatic blit_req_t pixel_req(input stb_pkg::cmd_t command, input int x,
                                          input int y,
                                          input logic [stb_pkg::COLOR_W-1:0] color);
    blit_req_t r;
    r         = random_req();
    r.command = command;
    r.pos_x   = stb_pkg::COORD_W'(x);
    r.pos_y   = stb_pkg::COORD_W'(y);
    r.color   = color;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one transaction, hold it until taken, then predict its writes.
  // Called at a rising edge; returns at an edge where in_stall is low again.
  task automatic send_item(input blit_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= r.command;
    in_pos_x        <= r.pos_x;
    in_pos_y        <= r.pos_y;
    in_size_w       <= r.size_w;
    in_size_h       <= r.size_h;
    in_pixel_format <= r.fmt;
    in_byte0        <= r.byte0;
    in_byte1        <= r.byte1;
    in_byte2        <= r.byte2;
    in_byte3        <= r.byte3;
    in_color        <= r.color;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (predict_fb_writes(r))
      items_applied++;
  endtask

  // Drop valid, wait for every owed write, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input stb_pkg::cfg_idx_t idx,
                         input logic [stb_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all five registers back to back; only called with the block idle.
  task automatic write_config(input logic [stb_pkg::CFG_DATA_W-1:0] scale_w,
                              input logic [stb_pkg::CFG_DATA_W-1:0] cols_w,
                              input logic [stb_pkg::CFG_DATA_W-1:0] rows_w,
                              input logic [stb_pkg::CFG_DATA_W-1:0] fbw_w,
                              input logic [stb_pkg::CFG_DATA_W-1:0] fbh_w);
    cfg_we <= 1'b1;
    cfg_put(stb_pkg::CFG_SCALE, scale_w);
    cfg_put(stb_pkg::CFG_TILE_COLS, cols_w);
    cfg_put(stb_pkg::CFG_TILE_ROWS, rows_w);
    cfg_put(stb_pkg::CFG_FB_WIDTH, fbw_w);
    cfg_put(stb_pkg::CFG_FB_HEIGHT, fbh_w);
    cfg_we <= 1'b0;
    // registers keep only their own width of the write data
    scale_reg     = scale_w[stb_pkg::SCALE_W-1:0];
    tile_cols_reg = cols_w[stb_pkg::COORD_W-1:0];
    tile_rows_reg = rows_w[stb_pkg::COORD_W-1:0];
    fb_width_reg  = fbw_w;
    fb_height_reg = fbh_w;
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Compare every write transaction with the oldest owed write.
  always @(posedge clk) begin : check_writes
    fb_write_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write index %h color %h",
                                  out_fb_index, out_fb_color));
      end else begin
        owed = pending_writes.pop_front();
        if (out_fb_index !== owed.index)
          report_mismatch($sformatf("fb_index %h, want %h", out_fb_index, owed.index));
        if (out_fb_color !== owed.color)
          report_mismatch($sformatf("fb_color %h, want %h", out_fb_color, owed.color));
        if (out_last_write !== owed.last)
          report_mismatch($sformatf("last_write %b, want %b", out_last_write, owed.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Widest registers: index wrap on raw and scaled pixels, key, clipping.
  task automatic test_pixel_extremes();
    write_config(13'd8, 13'd4095, 13'd4095, 13'd8191, 13'd4096);
    send_item(pixel_req(stb_pkg::CMD_RAW, 4095, 4095, 32'hFFFF_FFFF));
    send_item(pixel_req(stb_pkg::CMD_RAW, 0, 0, 32'h0000_0000));
    send_item(pixel_req(stb_pkg::CMD_RAW, 5, 5, stb_pkg::COLOR_KEY));
    send_item(pixel_req(stb_pkg::CMD_SCALED, 4094, 4094, 32'h5A5A_C3C3));
    send_item(pixel_req(stb_pkg::CMD_SCALED, 4095, 0, 32'h1234_5678));
    wait_idle();
  endtask

  // Blit at the far corner: transparent texel, full block, texel past the end.
  task automatic test_blit_edge();
    send_item(begin_req(4093, 4094, 2, 1, stb_pkg::FMT_ARGB));
    send_item(texel_req(8'h00, 8'h01, 8'h02, 8'h03));
    send_item(texel_req(8'h80, 8'h12, 8'h34, 8'h56));
    send_item(texel_req(8'hFF, 8'hAA, 8'hBB, 8'hCC));
    wait_idle();
  endtask

  // Small grid with fb_width zero: rejected begins, byte orders, key, clip.
  task automatic test_byte_orders();
    write_config(13'd2, 13'd3, 13'd2, 13'd0, 13'd8191);
    send_item(begin_req(0, 0, 2, 1, FMT_INVALID));
    send_item(texel_req(8'h11, 8'h22, 8'h33, 8'h44));
    send_item(begin_req(3, 0, 1, 1, stb_pkg::FMT_RGB));
    send_item(texel_req(8'h11, 8'h22, 8'h33, 8'h44));
    send_item(begin_req(0, 0, 0, 2, stb_pkg::FMT_RGB));
    send_item(texel_req(8'h11, 8'h22, 8'h33, 8'h44));
    send_item(begin_req(0, 0, 1, 1, stb_pkg::FMT_RGB));
    send_item(texel_req(8'h11, 8'h22, 8'h33, 8'h44));
    send_item(begin_req(0, 1, 2, 1, stb_pkg::FMT_BGR));
    send_item(texel_req(8'h11, 8'h22, 8'h33, 8'h44));
    send_item(texel_req(8'hFF, 8'h11, 8'hFF, 8'h00));  // swizzles to the key
    send_item(begin_req(2, 1, 2, 1, stb_pkg::FMT_BGRA));
    send_item(texel_req(8'hAA, 8'hBB, 8'hCC, 8'h80));
    send_item(texel_req(8'hAA, 8'hBB, 8'hCC, 8'h80));  // falls off the grid
    wait_idle();
  endtask

  // Scale zero writes no block; scale above the maximum saturates.
  // Upper write data bits are set to show the register keeps four bits.
  task automatic test_scale_limits();
    write_config(13'h1F0, 13'd6, 13'd6, 13'd64, 13'd64);
    send_item(pixel_req(stb_pkg::CMD_SCALED, 1, 1, 32'hCAFE_0001));
    send_item(pixel_req(stb_pkg::CMD_RAW, 2, 3, 32'hCAFE_0002));
    wait_idle();
    write_config(13'h00F, 13'd6, 13'd6, 13'd64, 13'd64);
    send_item(pixel_req(stb_pkg::CMD_SCALED, 5, 5, 32'hCAFE_0003));
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while items keep coming.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_config(13'd4, 13'd16, 13'd16, 13'd128, 13'd128);
    hold_requests++;
    repeat (8)
      send_item(pixel_req(stb_pkg::CMD_SCALED, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom));
    wait_idle();
  endtask

  // One random burst: mostly a begin and its texels, some pixels, some noise.
  task automatic random_burst(input int cols, input int rows, input int fbw);
    blit_req_t r;
    int        pick, w, h, extra, xmax;
    logic [7:0] alpha;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w     = $urandom_range(1, 4);
      h     = $urandom_range(1, 3);
      extra = $urandom_range(0, 1);
      send_item(begin_req($urandom_range(0, cols - 1), $urandom_range(0, rows - 1), w, h,
                          stb_pkg::FMT_W'($urandom_range(stb_pkg::FMT_RGB,
                                                         stb_pkg::FMT_BGRA))));
      repeat (w * h + extra) begin
        r     = texel_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        alpha = ($urandom_range(0, 7) == 0) ? 8'h00 : r.byte0;
        r.byte0 = alpha;
        r.byte3 = ($urandom_range(0, 7) == 0) ? 8'h00 : r.byte3;
        if ($urandom_range(0, 15) == 0) begin
          // key in the slots of the 0 and 4 byte orders
          r.byte0 = 8'hFF; r.byte1 = 8'h11; r.byte2 = 8'hFF;
        end
        send_item(r);
      end
    end else if (pick < 75) begin
      xmax = (fbw + 1 > 4095) ? 4095 : fbw + 1;
      send_item(pixel_req(stb_pkg::CMD_RAW, $urandom_range(0, xmax), $urandom_range(0, 90),
                          ($urandom_range(0, 9) == 0) ? stb_pkg::COLOR_KEY : $urandom));
    end else if (pick < 90) begin
      if ($urandom_range(0, 4) == 0)
        send_item(pixel_req(stb_pkg::CMD_SCALED, $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom));
      else
        send_item(pixel_req(stb_pkg::CMD_SCALED, $urandom_range(0, cols + 1),
                            $urandom_range(0, rows + 1),
                            ($urandom_range(0, 9) == 0) ? stb_pkg::COLOR_KEY : $urandom));
    end else begin
      // noise: anything at all, stray texels and wild begins included
      send_item(random_req());
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int scale_val, input int fbw_val);
    int cols, rows, target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    cols   = $urandom_range(2, 8);
    rows   = $urandom_range(2, 6);
    write_config(stb_pkg::CFG_DATA_W'(($urandom_range(0, 511) << stb_pkg::SCALE_W) |
                                      scale_val),
                 stb_pkg::CFG_DATA_W'(cols), stb_pkg::CFG_DATA_W'(rows),
                 stb_pkg::CFG_DATA_W'(fbw_val),
                 stb_pkg::CFG_DATA_W'($urandom_range(1, 80)));
    target = items_applied + PHASE_ITEMS;
    while (items_applied < target)
      random_burst(cols, rows, fbw_val);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = stb_pkg::CFG_SCALE;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_command      = stb_pkg::CMD_BEGIN;
    in_pos_x        = '0;
    in_pos_y        = '0;
    in_size_w       = '0;
    in_size_h       = '0;
    in_pixel_format = stb_pkg::FMT_RGB;
    in_byte0        = '0;
    in_byte1        = '0;
    in_byte2        = '0;
    in_byte3        = '0;
    in_color        = '0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_pixel_extremes();
    test_blit_edge();
    test_byte_orders();
    test_scale_limits();
    test_backpressure();
    test_random_traffic(0, 0, $urandom_range(1, BLIT_MAX_SCALE), $urandom_range(1, 80));
    test_random_traffic(71, 0, 1, 4096);
    test_random_traffic(0, 71, BLIT_MAX_SCALE, $urandom_range(1, 80));
    test_random_traffic(31, 31, $urandom_range(1, BLIT_MAX_SCALE), 8191);

    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("scaled_texture_blitter_test OK");
    end else begin
      $display("scaled_texture_blitter_test NOT OK");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost write ends here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("scaled_texture_blitter_test NOT OK");
    $finish;
  end

endmodule

// ----- scaled_texture_blitter.f -----
hdl/stb_pkg.sv
hdl/stb_ctrl.sv
hdl/stb_dpath.sv
hdl/scaled_texture_blitter.sv
test/scaled_texture_blitter_test.sv
